@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication, outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/mvs_pkg.sv @@
// Package: widths, operation codes and unit handshake types of the statistics block.
package mvs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_COUNT   = 4096;

  localparam int CNT_W    = $clog2(MAX_COUNT + 1);
  localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_COUNT);
  localparam int SQ_W     = 2 * SAMPLE_BITS - 1 + $clog2(MAX_COUNT);
  localparam int UNIT_W   = SQ_W + CNT_W;
  localparam int UNIT_B_W = SUM_W;

  localparam int MEAN_W  = 24;
  localparam int MSQ_W   = 31;
  localparam int VAR_W   = 31;
  localparam int COUNT_W = 13;
  localparam int FIELDS_W   = MEAN_W + MSQ_W + VAR_W + COUNT_W;
  localparam int M_TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } mvs_op_t;

  typedef struct packed {
    logic    start;
    mvs_op_t op;
  } mvs_unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mvs_unit_stat_t;

endpackage

@@ hw/rtl/mvs_shared_unit.sv @@
// Shared shift-add multiplier and restoring divider, one bit per cycle on one adder.
`include "assert_macros.svh"

module mvs_shared_unit import mvs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  mvs_unit_cmd_t         cmd,
  input  logic [UNIT_W-1:0]     opa,     // multiplicand or dividend
  input  logic [UNIT_B_W-1:0]   opb,     // multiplier or divisor
  output mvs_unit_stat_t        stat,
  output logic [UNIT_W-1:0]     result
);

  localparam int STEP_W = $clog2(UNIT_W);

  logic              busy;
  logic              done;
  mvs_op_t           op;
  logic [STEP_W-1:0] step;
  logic [UNIT_W-1:0] acc;
  logic [UNIT_W-1:0] quo;
  logic [UNIT_W-1:0] opnd;

  logic [UNIT_W:0]   add_x;
  logic [UNIT_W:0]   add_y;
  logic              sub;
  logic [UNIT_W:0]   add_r;
  logic              ge;

  // single adder: shift-add for multiply, trial subtract for divide
  always_comb begin
    unique case (op)
      OP_MUL: begin
        add_x = {1'b0, acc[UNIT_W-2:0], 1'b0};
        add_y = quo[UNIT_B_W-1] ? {1'b0, opnd} : '0;
        sub   = 1'b0;
      end
      default: begin
        add_x = {1'b0, acc[UNIT_W-2:0], quo[UNIT_W-1]};
        add_y = {1'b0, opnd};
        sub   = 1'b1;
      end
    endcase
    add_r = add_x + (sub ? ~add_y : add_y) + {{UNIT_W{1'b0}}, sub};
    ge    = !add_r[UNIT_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= OP_MUL;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        acc  <= '0;
        if (cmd.op == OP_MUL) begin
          opnd <= opa;
          quo  <= UNIT_W'(opb);
          step <= STEP_W'(UNIT_B_W - 1);
        end else begin
          opnd <= UNIT_W'(opb);
          quo  <= opa;
          step <= STEP_W'(UNIT_W - 1);
        end
      end else if (busy) begin
        if (op == OP_MUL) begin
          acc <= add_r[UNIT_W-1:0];
          quo <= {quo[UNIT_W-2:0], 1'b0};
        end else begin
          acc <= ge ? add_r[UNIT_W-1:0] : add_x[UNIT_W-1:0];
          quo <= {quo[UNIT_W-2:0], ge};
        end
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = (op == OP_MUL) ? acc : quo;

  `ASSERT_IMPL(a_start_when_free, clk, rst, cmd.start, !busy && !done, "unit started while busy")
  `ASSERT_IMPL(a_done_after_work, clk, rst, done, $past(busy), "unit done without work")

endmodule

@@ hw/rtl/vector_mean_variance_stats_top.sv @@
// Top level: running sums per vector and the end-of-vector mean and variance sequencer.
// Input: one transfer per cycle while the sequencer is idle; s_tready is low after tlast
// until the result is loaded. On tlast the sequencer runs three 28-step multiplies and two
// or three 56-step divides on the shared unit, one after another, then loads the result
// into the output register; the third divide runs only when the variance is positive.
// Reset (rst, synchronous): clears sums, count, drop flag, sequencer and output valid.
`include "assert_macros.svh"

module vector_mean_variance_stats_top import mvs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // [15:0] sample
  input  logic                 s_tlast,   // last element of the vector
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [23:0] mean, [54:24] mean_square,
                                          // [85:55] variance, [98:86] element_count,
                                          // [103:99] zero
  output logic                 m_tuser    // [0] overflow
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_S2,
    S_MUL_QN,
    S_MUL_NN,
    S_DIV_MEAN,
    S_DIV_MSQ,
    S_DIV_VAR,
    S_OUT
  } state_t;

  state_t state;
  logic   issued;

  // running state of the current vector
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sumsq;
  logic [CNT_W-1:0]        cnt;
  logic                    dropped;

  // intermediate products and quotients
  logic [UNIT_W-1:0]   s2;
  logic [UNIT_W-1:0]   qn;
  logic [2*CNT_W-1:0]  nn;
  logic [MEAN_W-1:0]   mean_q;
  logic [MSQ_W-1:0]    msq_q;
  logic [VAR_W-1:0]    var_q;

  logic signed [SAMPLE_BITS-1:0]   smp;
  logic signed [2*SAMPLE_BITS-1:0] smp_sq;
  logic [SUM_W-1:0]                sabs;
  logic [UNIT_W-1:0]               var_num;
  logic [MEAN_W-1:0]               mean_out;
  logic                            op_state;

  mvs_unit_cmd_t      unit_cmd;
  mvs_unit_stat_t     unit_stat;
  logic [UNIT_W-1:0]  unit_a;
  logic [UNIT_B_W-1:0] unit_b;
  logic [UNIT_W-1:0]  unit_res;

  assign smp      = s_tdata[SAMPLE_BITS-1:0];
  assign smp_sq   = smp * smp;
  assign sabs     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign var_num  = qn - s2;
  assign mean_out = sum[SUM_W-1] ? MEAN_W'(~mean_q + 1'b1) : mean_q;
  assign s_tready = (state == S_IDLE);

  assign op_state = (state != S_IDLE) && (state != S_OUT);

  // operand selection for the shared unit
  always_comb begin
    unit_cmd.start = op_state && !issued;
    unit_cmd.op    = OP_DIV;
    unit_a         = '0;
    unit_b         = '0;
    unique case (state)
      S_MUL_S2: begin
        unit_cmd.op = OP_MUL;
        unit_a      = UNIT_W'(sabs);
        unit_b      = sabs;
      end
      S_MUL_QN: begin
        unit_cmd.op = OP_MUL;
        unit_a      = UNIT_W'(sumsq);
        unit_b      = UNIT_B_W'(cnt);
      end
      S_MUL_NN: begin
        unit_cmd.op = OP_MUL;
        unit_a      = UNIT_W'(cnt);
        unit_b      = UNIT_B_W'(cnt);
      end
      S_DIV_MEAN: begin
        unit_a = UNIT_W'({sabs, 8'd0});
        unit_b = UNIT_B_W'(cnt);
      end
      S_DIV_MSQ: begin
        unit_a = UNIT_W'(sumsq);
        unit_b = UNIT_B_W'(cnt);
      end
      S_DIV_VAR: begin
        unit_a = var_num;
        unit_b = UNIT_B_W'(nn);
      end
      default: begin
        unit_cmd.op = OP_DIV;
      end
    endcase
  end

  mvs_shared_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .cmd    (unit_cmd),
    .opa    (unit_a),
    .opb    (unit_b),
    .stat   (unit_stat),
    .result (unit_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      issued   <= 1'b0;
      sum      <= '0;
      sumsq    <= '0;
      cnt      <= '0;
      dropped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the held result once the downstream side takes it, unless a new one loads
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      if (unit_cmd.start) begin
        issued <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            // accumulate while below the limit, otherwise drop and flag
            if (cnt < CNT_W'(MAX_COUNT)) begin
              sum   <= sum + SUM_W'(smp);
              sumsq <= sumsq + SQ_W'($unsigned(smp_sq));
              cnt   <= cnt + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (s_tlast) begin
              state <= S_MUL_S2;
            end
          end
        end
        S_MUL_S2: begin
          if (issued && unit_stat.done) begin
            s2     <= unit_res;
            issued <= 1'b0;
            state  <= S_MUL_QN;
          end
        end
        S_MUL_QN: begin
          if (issued && unit_stat.done) begin
            qn     <= unit_res;
            issued <= 1'b0;
            state  <= S_MUL_NN;
          end
        end
        S_MUL_NN: begin
          if (issued && unit_stat.done) begin
            nn     <= unit_res[2*CNT_W-1:0];
            issued <= 1'b0;
            state  <= S_DIV_MEAN;
          end
        end
        S_DIV_MEAN: begin
          if (issued && unit_stat.done) begin
            mean_q <= unit_res[MEAN_W-1:0];
            issued <= 1'b0;
            state  <= S_DIV_MSQ;
          end
        end
        S_DIV_MSQ: begin
          if (issued && unit_stat.done) begin
            msq_q  <= unit_res[MSQ_W-1:0];
            issued <= 1'b0;
            // skip the variance divide when the difference is not positive
            if (qn > s2) begin
              state <= S_DIV_VAR;
            end else begin
              var_q <= '0;
              state <= S_OUT;
            end
          end
        end
        S_DIV_VAR: begin
          if (issued && unit_stat.done) begin
            var_q  <= unit_res[VAR_W-1:0];
            issued <= 1'b0;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free, then load and clear the vector
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {{(M_TDATA_W - FIELDS_W){1'b0}}, COUNT_W'(cnt), var_q, msq_q,
                         mean_out};
            m_tuser  <= dropped;
            m_tvalid <= 1'b1;
            sum      <= '0;
            sumsq    <= '0;
            cnt      <= '0;
            dropped  <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_cnt_limit, clk, rst, cnt <= CNT_W'(MAX_COUNT), "count above limit")
  `ASSERT_IMPL(a_drop_when_full, clk, rst, dropped, cnt == CNT_W'(MAX_COUNT), "drop below limit")
  `ASSERT_IMPL(a_wait_on_unit, clk, rst, issued, unit_stat.busy || unit_stat.done, "unit idle while awaited")

endmodule

@@ tb/vector_mean_variance_stats_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the vector mean and variance statistics block.
module vector_mean_variance_stats_top_tb import mvs_pkg::*;;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_GAP      = 19;
  // Quiet cycles allowed with no transfer on either side: covers the sequencer's work
  // after the last element, plus the longest receiver stall.
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1250;
  localparam int REPORT_MAX   = 10;

  // One end-of-vector result, as carried on m_tdata and m_tuser.
  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [MSQ_W-1:0]         mean_square;
    logic [VAR_W-1:0]         variance;
    logic [COUNT_W-1:0]       count;
    logic                     overflow;
  } stats_t;

  // One row of the directed table; fixed_want is used when use_fixed is set.
  typedef struct {
    logic signed [15:0] sample;
    logic               last;
    bit                 use_fixed;
    stats_t             fixed_want;
  } vec_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [15:0]          s_tdata;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  // Shadow accumulators of the block, kept at its own widths.
  logic signed [SUM_W-1:0] acc_sum;
  logic [SQ_W-1:0]         acc_sq;
  logic [CNT_W-1:0]        acc_count;
  logic                    acc_dropped;

  stats_t   pending_stats[$];
  vec_row_t vec_table[$];
  int       fault_count;
  int       quiet_cycles;
  bit       sender_gaps;
  bit       receiver_gaps;

  vector_mean_variance_stats_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // Fold one element into the shadow sums; on the last element return the
  // statistics of the vector and clear the sums.
  function automatic bit accumulate_element(input logic signed [15:0] smp,
                                            input logic lst, output stats_t res);
    longint          tot;
    longint unsigned n, sabs, qn, s2, mabs;
    res = '0;
    if (acc_count < MAX_COUNT) begin
      acc_sum   = acc_sum + smp;
      acc_sq    = SQ_W'(acc_sq + longint'(smp) * longint'(smp));
      acc_count = acc_count + 1'b1;
    end else begin
      acc_dropped = 1'b1;
    end
    if (!lst) return 1'b0;
    tot  = acc_sum;
    n    = acc_count;
    sabs = (tot < 0) ? -tot : tot;
    qn   = longint'(acc_sq) * n;
    s2   = sabs * sabs;
    mabs = (sabs * 256) / n;
    res.mean        = MEAN_W'((tot < 0) ? -longint'(mabs) : longint'(mabs));
    res.mean_square = MSQ_W'(acc_sq / n);
    res.variance    = VAR_W'((qn > s2) ? (qn - s2) / (n * n) : 64'd0);
    res.count       = COUNT_W'(n);
    res.overflow    = acc_dropped;
    acc_sum     = '0;
    acc_sq      = '0;
    acc_count   = '0;
    acc_dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic signed [15:0] smp, input logic lst,
                                  input bit use_fixed, input stats_t want);
    vec_row_t row;
    row.sample     = smp;
    row.last       = lst;
    row.use_fixed  = use_fixed;
    row.fixed_want = want;
    vec_table.push_back(row);
  endfunction

  // Present one element, hold it until the transfer, then queue what it yields.
  // Call at a falling edge; return at the falling edge after the transfer.
  task automatic send_element(input logic signed [15:0] smp, input logic lst,
                              input bit use_fixed, input stats_t fixed_want);
    int     gap;
    stats_t res;
    gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    if (accumulate_element(smp, lst, res))
      pending_stats.push_back(use_fixed ? fixed_want : res);
    @(negedge clk);
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_stats.size() != 0);
  endtask

  task automatic check_result(input logic [M_TDATA_W-1:0] data, input logic ovf);
    stats_t got, want;
    got.mean        = data[MEAN_W-1:0];
    got.mean_square = data[MEAN_W +: MSQ_W];
    got.variance    = data[MEAN_W+MSQ_W +: VAR_W];
    got.count       = data[MEAN_W+MSQ_W+VAR_W +: COUNT_W];
    got.overflow    = ovf;
    if (pending_stats.size() == 0) begin
      if (fault_count < REPORT_MAX)
        $display("[%0t] result with nothing expected: mean %0d msq %0d var %0d n %0d ovf %0b",
                 $realtime, got.mean, got.mean_square, got.variance, got.count,
                 got.overflow);
      fault_count++;
    end else begin
      want = pending_stats.pop_front();
      if (got.mean != want.mean || got.mean_square != want.mean_square ||
          got.variance != want.variance || got.count != want.count ||
          got.overflow != want.overflow) begin
        if (fault_count < REPORT_MAX) begin
          $display("[%0t] result mismatch", $realtime);
          $display("  expected: mean %0d msq %0d var %0d n %0d ovf %0b",
                   want.mean, want.mean_square, want.variance, want.count, want.overflow);
          $display("  actual:   mean %0d msq %0d var %0d n %0d ovf %0b",
                   got.mean, got.mean_square, got.variance, got.count, got.overflow);
        end
        fault_count++;
      end
    end
  endtask

  // Receiver: stall for a drawn number of cycles before each result, sometimes
  // only once the result is already waiting, and check every transfer.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(negedge clk);
      stall = receiver_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        if ($urandom_range(0, 1) == 1)
          while (!m_tvalid) @(negedge clk);
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_result(m_tdata, m_tuser);
      if ($urandom_range(0, 7) == 0) receiver_gaps = ~receiver_gaps;
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stats_t none, want;
    int     items_sent, vec_len, style, k;
    logic signed [15:0] smp, level;

    clk           = 1'b0;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    m_tready      = 1'b0;
    acc_sum       = '0;
    acc_sq        = '0;
    acc_count     = '0;
    acc_dropped   = 1'b0;
    fault_count   = 0;
    quiet_cycles  = 0;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    none          = '0;

    // Single-element vectors: zero, both extremes and minus one, values fixed.
    add_row(16'sd0, 1'b1, 1'b1, '{mean: 0, mean_square: 0, variance: 0, count: 1, overflow: 0});
    add_row(16'sd32767, 1'b1, 1'b1,
            '{mean: 8388352, mean_square: 1073676289, variance: 0, count: 1, overflow: 0});
    add_row(-16'sd32768, 1'b1, 1'b1,
            '{mean: -8388608, mean_square: 1073741824, variance: 0, count: 1, overflow: 0});
    add_row(-16'sd1, 1'b1, 1'b1, '{mean: -256, mean_square: 1, variance: 0, count: 1, overflow: 0});
    // Opposite extremes: widest spread for two elements.
    add_row(16'sd32767, 1'b0, 1'b0, none);
    add_row(-16'sd32768, 1'b1, 1'b0, none);
    // Negative mean that truncates toward zero, then a short positive vector.
    add_row(-16'sd1, 1'b0, 1'b0, none);
    add_row(-16'sd1, 1'b0, 1'b0, none);
    add_row(16'sd0, 1'b1, 1'b0, none);
    add_row(16'sd1, 1'b0, 1'b0, none);
    add_row(16'sd2, 1'b1, 1'b0, none);
    // Mixed magnitudes, every sample bit in both states.
    add_row(-16'sd300, 1'b0, 1'b0, none);
    add_row(16'sd77, 1'b0, 1'b0, none);
    add_row(16'sd12345, 1'b0, 1'b0, none);
    add_row(-16'sd32768, 1'b0, 1'b0, none);
    add_row(16'sd32767, 1'b0, 1'b0, none);
    add_row(16'sd5, 1'b1, 1'b0, none);
    add_row(16'sh5555, 1'b0, 1'b0, none);
    add_row(16'shAAAA, 1'b1, 1'b0, none);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (vec_table[i])
      send_element(vec_table[i].sample, vec_table[i].last, vec_table[i].use_fixed,
                   vec_table[i].fixed_want);
    drain_results();

    // Full-length vector of the largest sample: no drop, mean at its top.
    sender_gaps = 1'b1;
    want = '{mean: 8388352, mean_square: 1073676289, variance: 0, count: 4096, overflow: 0};
    for (k = 0; k < MAX_COUNT; k++)
      send_element(16'sd32767, k == MAX_COUNT - 1, k == MAX_COUNT - 1, want);

    // Vector too long: two extra elements, the last one included, are dropped.
    sender_gaps = 1'b0;
    want = '{mean: -8388608, mean_square: 1073741824, variance: 0, count: 4096, overflow: 1};
    for (k = 0; k < MAX_COUNT + 2; k++)
      send_element(-16'sd32768, k == MAX_COUNT + 1, k == MAX_COUNT + 1, want);
    drain_results();

    // Random vectors: mostly short, some longer, each with its own sample style.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:             vec_len = $urandom_range(41, 200);
        1, 2, 3, 4, 5: vec_len = $urandom_range(9, 40);
        default:       vec_len = $urandom_range(1, 8);
      endcase
      style       = $urandom_range(0, 5);
      level       = 16'($urandom_range(0, 65535));
      sender_gaps = ($urandom_range(0, 3) != 0);
      for (k = 0; k < vec_len; k++) begin
        case (style)
          0, 1: smp = 16'($urandom_range(0, 65535));
          2:    smp = $signed(16'($urandom_range(0, 511))) - 16'sd256;
          3: begin
            case ($urandom_range(0, 3))
              0:       smp = 16'sd32767;
              1:       smp = -16'sd32768;
              2:       smp = -16'sd1;
              default: smp = 16'sd0;
            endcase
          end
          4:       smp = level;
          default: smp = level + $signed(16'($urandom_range(0, 3)));
        endcase
        send_element(smp, k == vec_len - 1, 1'b0, none);
      end
      items_sent += vec_len;
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
